@@ sv/ascpu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ascpu_pkg: shared types and constants of the accumulator CPU core
// Opcodes, run states, access kinds, input modes, ALU operations and the
// sequencer state type used by the core and its shared arithmetic unit.
// ----------------------------------------------------------------------------
package ascpu_pkg;

    localparam int unsigned LEN_BITS   = 13;
    localparam int unsigned COUNT_BITS = 25;
    localparam int unsigned WORD_BITS  = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
    localparam logic [COUNT_BITS-1:0] LIMIT_RESET = COUNT_BITS'(1 << 24);

    // Input modes. The unused fourth code behaves like a peek.
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_STEP = 2'd1;
    localparam logic [1:0] MODE_PEEK = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_PROGRAM_LENGTH = 1'b0;
    localparam logic CFG_STEP_LIMIT     = 1'b1;

    // Opcodes; everything from OP_HALT upward halts the machine.
    localparam logic [7:0] OP_LDC    = 8'd0;
    localparam logic [7:0] OP_ADC    = 8'd1;
    localparam logic [7:0] OP_LDL    = 8'd2;
    localparam logic [7:0] OP_STL    = 8'd3;
    localparam logic [7:0] OP_LDNL   = 8'd4;
    localparam logic [7:0] OP_STNL   = 8'd5;
    localparam logic [7:0] OP_ADD    = 8'd6;
    localparam logic [7:0] OP_SUB    = 8'd7;
    localparam logic [7:0] OP_SHL    = 8'd8;
    localparam logic [7:0] OP_SHR    = 8'd9;
    localparam logic [7:0] OP_ADJ    = 8'd10;
    localparam logic [7:0] OP_A2SP   = 8'd11;
    localparam logic [7:0] OP_SP2A   = 8'd12;
    localparam logic [7:0] OP_CALL   = 8'd13;
    localparam logic [7:0] OP_RETURN = 8'd14;
    localparam logic [7:0] OP_BRZ    = 8'd15;
    localparam logic [7:0] OP_BRLZ   = 8'd16;
    localparam logic [7:0] OP_BR     = 8'd17;
    localparam logic [7:0] OP_HALT   = 8'd18;

    typedef enum logic [1:0] {
        RUN_ACTIVE = 2'd0,
        RUN_HALTED = 2'd1,
        RUN_DONE   = 2'd2,
        RUN_ERROR  = 2'd3
    } t_run_state;

    typedef enum logic [1:0] {
        ACC_NONE  = 2'd0,
        ACC_READ  = 2'd1,
        ACC_WRITE = 2'd2
    } t_access;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_SHL,
        ALU_SHR
    } t_alu_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_EXEC,
        S_CHECK,
        S_OUT
    } t_seq_state;

    // Sign-extended 24-bit operand of an instruction word.
    function automatic logic [WORD_BITS-1:0] operand_of(input logic [WORD_BITS-1:0] w);
        operand_of = {{8{w[31]}}, w[31:8]};
    endfunction

endpackage
`default_nettype wire

@@ sv/ascpu_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ascpu_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered and holds its
// value while the read enable is low.
// ----------------------------------------------------------------------------
module ascpu_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ sv/ascpu_alu.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ascpu_alu: shared arithmetic and shift unit
// One adder/subtractor and one barrel shifter, reused by the sequencer for
// address generation, accumulator arithmetic and branch targets.
// ----------------------------------------------------------------------------
module ascpu_alu (
    input  wire ascpu_pkg::t_alu_op   i_op,
    input  wire logic [31:0]          i_a,
    input  wire logic [31:0]          i_b,
    output logic      [31:0]          o_result
);

    logic big_shift;

    assign big_shift = (i_b[31:5] != 27'd0);

    always_comb begin
        case (i_op)
            ascpu_pkg::ALU_ADD: o_result = i_a + i_b;
            ascpu_pkg::ALU_SUB: o_result = i_a - i_b;
            ascpu_pkg::ALU_SHL: o_result = big_shift ? 32'd0 : (i_a << i_b[4:0]);
            ascpu_pkg::ALU_SHR: begin
                // Arithmetic shift; amounts of 32 or more leave only the sign fill.
                o_result = big_shift ? {32{i_a[31]}} : 32'($signed(i_a) >>> i_b[4:0]);
            end
            default:            o_result = i_a + i_b;
        endcase
    end

endmodule
`default_nettype wire

@@ sv/accumulator_stack_cpu_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// accumulator_stack_cpu_core: 32-bit accumulator machine with stream ports
// Executes at most one instruction, loads one program word or peeks one
// data word per input item, and returns one result item for every input item.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on the s_axis channel: tuser carries the mode (load,
// step, peek), tdata the word address and the data word. Each item yields
// exactly one result item on the m_axis channel with the architectural
// registers, run status, executed opcode and data access details.
// The core works on one item at a time under a small sequencer that drives
// one shared adder/shifter and two RAMs with registered reads. A load, a
// peek or a step on a stopped machine passes through the decode and output
// states only; a step that executes passes through decode, code fetch,
// execute with the data read, status check and output, as the code read and
// the data read are registered reads in series.
// After reset the data store is swept to zero, one word per cycle, across
// all 2**ADDR_BITS words; input tready stays low meanwhile, while configuration
// writes are taken at any time. The code store is not cleared.
// The result sits in an output register; while the receiver stalls, the core
// still accepts and processes the next item and waits only when that item's
// result is ready to be written.
// ----------------------------------------------------------------------------
module accumulator_stack_cpu_core #(
    parameter int unsigned ADDR_BITS = 12
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,

    // Input items.
    input  wire logic                                   i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    // tdata, lowest bit up: address[ADDR_BITS], data[32], zero fill.
    input  wire logic [((ADDR_BITS+32+7)/8)*8-1:0]      i_s_axis_tdata,
    // tuser: mode[2].
    input  wire logic [1:0]                             i_s_axis_tuser,

    // Result items.
    output logic                                        o_m_axis_tvalid,
    input  wire logic                                   i_m_axis_tready,
    // tdata, lowest bit up: pc_out[32], sp_out[32], acc_out[32], regb_out[32],
    // status[2], executed_opcode[8], access_address[ADDR_BITS],
    // old_value[32], peek_data[32], zero fill.
    output logic      [((ADDR_BITS+202+7)/8)*8-1:0]     o_m_axis_tdata,
    // tuser: access_kind[2].
    output logic      [1:0]                             o_m_axis_tuser,

    // Configuration writes.
    input  wire logic                                   i_cfg_we,
    input  wire logic                                   i_cfg_index,
    input  wire logic [ascpu_pkg::COUNT_BITS-1:0]       i_cfg_data
);

    localparam int unsigned AW    = ADDR_BITS;
    localparam int unsigned DEPTH = 1 << ADDR_BITS;
    localparam int unsigned OUT_W = ((ADDR_BITS + 202 + 7) / 8) * 8;
    localparam int unsigned LW    = ascpu_pkg::LEN_BITS;
    localparam int unsigned CW    = ascpu_pkg::COUNT_BITS;

    // Sequencer and architectural state.
    ascpu_pkg::t_seq_state r_state, n_state;
    ascpu_pkg::t_run_state r_run,   n_run;
    logic [31:0]           r_acc,   n_acc;
    logic [31:0]           r_b,     n_b;
    logic [31:0]           r_pc,    n_pc;
    logic [31:0]           r_sp,    n_sp;
    logic [CW-1:0]         r_cnt,   n_cnt;
    logic [LW-1:0]         r_len,   n_len;
    logic [CW-1:0]         r_limit, n_limit;
    logic [AW-1:0]         r_clr,   n_clr;
    logic                  r_out_valid, n_out_valid;

    // Per-item working registers.
    logic [1:0]            r_mode,  n_mode;
    logic [AW-1:0]         r_addr,  n_addr;
    logic [31:0]           r_data,  n_data;
    logic [AW-1:0]         r_maddr, n_maddr;
    logic [7:0]            r_opc,   n_opc;
    ascpu_pkg::t_access    r_kind,  n_kind;
    logic [31:0]           r_oldv,  n_oldv;
    logic [OUT_W-1:0]      r_out_data, n_out_data;
    logic [1:0]            r_out_user, n_out_user;

    // Memory ports.
    logic          dram_we, dram_re, cram_we, cram_re;
    logic [AW-1:0] dram_waddr, dram_raddr;
    logic [31:0]   dram_wdata, dram_rdata, cram_rdata;

    // Shared arithmetic unit.
    ascpu_pkg::t_alu_op alu_op;
    logic [31:0]        alu_a, alu_b, alu_res;
    logic [31:0]        operand;
    logic [31:0]        peek_val;

    assign operand  = ascpu_pkg::operand_of(cram_rdata);
    assign peek_val = ((r_mode == ascpu_pkg::MODE_LOAD) || (r_mode == ascpu_pkg::MODE_STEP))
                      ? 32'd0 : dram_rdata;

    ascpu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (cram_we),
        .i_waddr (r_addr),
        .i_wdata (r_data),
        .i_re    (cram_re),
        .i_raddr (r_pc[AW-1:0]),
        .o_rdata (cram_rdata)
    );

    ascpu_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (dram_we),
        .i_waddr (dram_waddr),
        .i_wdata (dram_wdata),
        .i_re    (dram_re),
        .i_raddr (dram_raddr),
        .o_rdata (dram_rdata)
    );

    ascpu_alu u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_result (alu_res)
    );

    assign o_s_axis_tready = (r_state == ascpu_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    always_comb begin
        n_state     = r_state;
        n_run       = r_run;
        n_acc       = r_acc;
        n_b         = r_b;
        n_pc        = r_pc;
        n_sp        = r_sp;
        n_cnt       = r_cnt;
        n_len       = r_len;
        n_limit     = r_limit;
        n_clr       = r_clr;
        n_out_valid = r_out_valid;
        n_mode      = r_mode;
        n_addr      = r_addr;
        n_data      = r_data;
        n_maddr     = r_maddr;
        n_opc       = r_opc;
        n_kind      = r_kind;
        n_oldv      = r_oldv;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;

        dram_we    = 1'b0;
        dram_waddr = r_addr;
        dram_wdata = r_data;
        dram_re    = 1'b0;
        dram_raddr = r_addr;
        cram_we    = 1'b0;
        cram_re    = 1'b0;

        alu_op = ascpu_pkg::ALU_ADD;
        alu_a  = r_acc;
        alu_b  = operand;

        // The receiver taking the held result frees the output register.
        if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        // Configuration writes are taken in every state.
        if (i_cfg_we) begin
            case (i_cfg_index)
                ascpu_pkg::CFG_PROGRAM_LENGTH: n_len   = i_cfg_data[LW-1:0];
                ascpu_pkg::CFG_STEP_LIMIT:     n_limit = i_cfg_data;
                default:                       n_len   = r_len;
            endcase
        end

        case (r_state)
            ascpu_pkg::S_CLEAR: begin
                dram_we    = 1'b1;
                dram_waddr = r_clr;
                dram_wdata = 32'd0;
                n_clr      = r_clr + 1'b1;
                if (r_clr == {AW{1'b1}}) begin
                    n_state = ascpu_pkg::S_IDLE;
                end
            end

            ascpu_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_mode  = i_s_axis_tuser;
                    n_addr  = i_s_axis_tdata[AW-1:0];
                    n_data  = i_s_axis_tdata[AW +: 32];
                    n_maddr = '0;
                    n_opc   = ascpu_pkg::OP_LDC;
                    n_kind  = ascpu_pkg::ACC_NONE;
                    n_oldv  = 32'd0;
                    n_state = ascpu_pkg::S_DECODE;
                end
            end

            ascpu_pkg::S_DECODE: begin
                case (r_mode)
                    ascpu_pkg::MODE_LOAD: begin
                        cram_we = 1'b1;
                        dram_we = 1'b1;
                        n_state = ascpu_pkg::S_OUT;
                    end
                    ascpu_pkg::MODE_STEP: begin
                        if (r_run != ascpu_pkg::RUN_ACTIVE) begin
                            n_state = ascpu_pkg::S_OUT;
                        end else if (r_pc >= 32'(r_len)) begin
                            n_run   = ascpu_pkg::RUN_DONE;
                            n_state = ascpu_pkg::S_OUT;
                        end else begin
                            cram_re = 1'b1;
                            n_state = ascpu_pkg::S_FETCH;
                        end
                    end
                    default: begin
                        // Peek; the read data is picked up in the output state.
                        dram_re = 1'b1;
                        n_state = ascpu_pkg::S_OUT;
                    end
                endcase
            end

            ascpu_pkg::S_FETCH: begin
                // The adder forms the data address: SP-relative for local
                // accesses, A-relative for non-local ones. Only memory
                // instructions report it; all others keep the address at zero.
                n_opc = cram_rdata[7:0];
                if ((cram_rdata[7:0] == ascpu_pkg::OP_LDL) ||
                    (cram_rdata[7:0] == ascpu_pkg::OP_STL)) begin
                    alu_a = r_sp;
                end else begin
                    alu_a = r_acc;
                end
                alu_b      = operand;
                dram_raddr = alu_res[AW-1:0];
                case (cram_rdata[7:0])
                    ascpu_pkg::OP_LDL, ascpu_pkg::OP_STL,
                    ascpu_pkg::OP_LDNL, ascpu_pkg::OP_STNL: begin
                        dram_re = 1'b1;
                        n_maddr = alu_res[AW-1:0];
                    end
                    default: dram_re = 1'b0;
                endcase
                n_pc = r_pc + 32'd1;
                if (r_cnt != ascpu_pkg::COUNT_MAX) begin
                    n_cnt = r_cnt + 1'b1;
                end
                n_state = ascpu_pkg::S_EXEC;
            end

            ascpu_pkg::S_EXEC: begin
                dram_waddr = r_maddr;
                n_state    = ascpu_pkg::S_CHECK;
                case (r_opc)
                    ascpu_pkg::OP_LDC: begin
                        n_b   = r_acc;
                        n_acc = operand;
                    end
                    ascpu_pkg::OP_ADC: begin
                        alu_a = r_acc;
                        alu_b = operand;
                        n_acc = alu_res;
                    end
                    ascpu_pkg::OP_LDL: begin
                        n_b    = r_acc;
                        n_acc  = dram_rdata;
                        n_kind = ascpu_pkg::ACC_READ;
                    end
                    ascpu_pkg::OP_STL: begin
                        dram_we    = 1'b1;
                        dram_wdata = r_acc;
                        n_oldv     = dram_rdata;
                        n_acc      = r_b;
                        n_kind     = ascpu_pkg::ACC_WRITE;
                    end
                    ascpu_pkg::OP_LDNL: begin
                        n_acc  = dram_rdata;
                        n_kind = ascpu_pkg::ACC_READ;
                    end
                    ascpu_pkg::OP_STNL: begin
                        dram_we    = 1'b1;
                        dram_wdata = r_b;
                        n_oldv     = dram_rdata;
                        n_kind     = ascpu_pkg::ACC_WRITE;
                    end
                    ascpu_pkg::OP_ADD: begin
                        alu_a = r_acc;
                        alu_b = r_b;
                        n_acc = alu_res;
                    end
                    ascpu_pkg::OP_SUB: begin
                        alu_op = ascpu_pkg::ALU_SUB;
                        alu_a  = r_b;
                        alu_b  = r_acc;
                        n_acc  = alu_res;
                    end
                    ascpu_pkg::OP_SHL: begin
                        alu_op = ascpu_pkg::ALU_SHL;
                        alu_a  = r_b;
                        alu_b  = r_acc;
                        n_acc  = alu_res;
                    end
                    ascpu_pkg::OP_SHR: begin
                        alu_op = ascpu_pkg::ALU_SHR;
                        alu_a  = r_b;
                        alu_b  = r_acc;
                        n_acc  = alu_res;
                    end
                    ascpu_pkg::OP_ADJ: begin
                        alu_a = r_sp;
                        alu_b = operand;
                        n_sp  = alu_res;
                    end
                    ascpu_pkg::OP_A2SP: begin
                        n_sp  = r_acc;
                        n_acc = r_b;
                    end
                    ascpu_pkg::OP_SP2A: begin
                        n_b   = r_acc;
                        n_acc = r_sp;
                    end
                    ascpu_pkg::OP_CALL: begin
                        // PC already points past the call, which is the
                        // return address.
                        n_b   = r_acc;
                        n_acc = r_pc;
                        alu_a = r_pc;
                        alu_b = operand;
                        n_pc  = alu_res;
                    end
                    ascpu_pkg::OP_RETURN: begin
                        n_pc  = r_acc;
                        n_acc = r_b;
                    end
                    ascpu_pkg::OP_BRZ: begin
                        alu_a = r_pc;
                        alu_b = operand;
                        if (r_acc == 32'd0) begin
                            n_pc = alu_res;
                        end
                    end
                    ascpu_pkg::OP_BRLZ: begin
                        alu_a = r_pc;
                        alu_b = operand;
                        if (r_acc[31]) begin
                            n_pc = alu_res;
                        end
                    end
                    ascpu_pkg::OP_BR: begin
                        alu_a = r_pc;
                        alu_b = operand;
                        n_pc  = alu_res;
                    end
                    default: begin
                        // Halting opcodes change no register in this state.
                        n_acc = r_acc;
                    end
                endcase
            end

            ascpu_pkg::S_CHECK: begin
                // Error has priority over halt, halt over finishing.
                if (r_pc[31] || (r_pc > 32'(r_len)) || (r_cnt > r_limit)) begin
                    n_run = ascpu_pkg::RUN_ERROR;
                end else if (r_opc >= ascpu_pkg::OP_HALT) begin
                    n_run = ascpu_pkg::RUN_HALTED;
                end else if (r_pc >= 32'(r_len)) begin
                    n_run = ascpu_pkg::RUN_DONE;
                end
                n_state = ascpu_pkg::S_OUT;
            end

            ascpu_pkg::S_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_W'({peek_val, r_oldv, r_maddr, r_opc, r_run,
                                          r_b, r_acc, r_sp, r_pc});
                    n_out_user  = r_kind;
                    n_state     = ascpu_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ascpu_pkg::S_IDLE;
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ascpu_pkg::S_CLEAR;
            r_run       <= ascpu_pkg::RUN_ACTIVE;
            r_acc       <= 32'd0;
            r_b         <= 32'd0;
            r_pc        <= 32'd0;
            r_sp        <= 32'd0;
            r_cnt       <= '0;
            r_len       <= '0;
            r_limit     <= ascpu_pkg::LIMIT_RESET;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run       <= n_run;
            r_acc       <= n_acc;
            r_b         <= n_b;
            r_pc        <= n_pc;
            r_sp        <= n_sp;
            r_cnt       <= n_cnt;
            r_len       <= n_len;
            r_limit     <= n_limit;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // Per-item payload; every field is written before it is used.
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_addr     <= n_addr;
        r_data     <= n_data;
        r_maddr    <= n_maddr;
        r_opc      <= n_opc;
        r_kind     <= n_kind;
        r_oldv     <= n_oldv;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

endmodule
`default_nettype wire

@@ verif/tb_accumulator_stack_cpu_core.sv @@
// ----------------------------------------------------------------------------
// tb_accumulator_stack_cpu_core: self-checking bench for the accumulator core
// Loads program words, single-steps the machine and peeks data words through
// the input stream, mirrors every item in a scoreboard model of the machine
// and compares each result item field by field, under random idling on both
// sides of the core.
// ----------------------------------------------------------------------------
module tb_accumulator_stack_cpu_core;

    localparam int AB  = 12;                       // address bits of both stores
    localparam int S_W = ((AB + 32 + 7) / 8) * 8;  // input tdata width
    localparam int M_W = ((AB + 202 + 7) / 8) * 8; // result tdata width
    localparam int CB  = ascpu_pkg::COUNT_BITS;
    localparam int LB  = ascpu_pkg::LEN_BITS;

    // Result tdata field offsets, lowest bit up.
    localparam int F_STATUS = 128;
    localparam int F_OPCODE = 130;
    localparam int F_ADDR   = 138;
    localparam int F_OLD    = F_ADDR + AB;
    localparam int F_PEEK   = F_OLD + 32;

    // The spare mode code, which the core handles as a peek.
    localparam logic [1:0] MODE_PEEK_ALT = 2'd3;

    localparam int unsigned MAX_LENGTH    = 4096;
    localparam int unsigned MAX_LIMIT     = 1 << 24;
    localparam int          RANDOM_ITEMS  = 1300;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          PRINT_LIMIT   = 200;

    // Ways in which the single execution run of the bench is brought to an end.
    typedef enum {
        END_HALT,
        END_AT_LENGTH,
        END_PAST_LENGTH,
        END_NEGATIVE_PC,
        END_STEP_LIMIT,
        END_LENGTH_CUT
    } t_ending;

    typedef struct packed {
        logic [31:0]            pc;
        logic [31:0]            sp;
        logic [31:0]            acc;
        logic [31:0]            breg;
        ascpu_pkg::t_run_state  status;
        logic [7:0]             opcode;
        ascpu_pkg::t_access     kind;
        logic [AB-1:0]          aaddr;
        logic [31:0]            old;
        logic [31:0]            peek;
    } t_machine_view;

    // Scoreboard: a model of the machine that turns every accepted input item
    // into the result item it must cause, and a queue of those results.
    class core_mirror;
        logic [31:0]            code_mem [0:(1<<AB)-1];
        logic [31:0]            data_mem [0:(1<<AB)-1];
        logic [31:0]            acc, breg, pc, sp;
        logic [CB-1:0]          executed;
        logic [CB-1:0]          limit_steps;
        logic [LB-1:0]          length_words;
        ascpu_pkg::t_run_state  run;
        t_machine_view          pending_results [$];
        int                     mismatches;

        function new();
            foreach (data_mem[i]) data_mem[i] = '0;
            acc = '0;
            breg = '0;
            pc = '0;
            sp = '0;
            executed = '0;
            limit_steps = ascpu_pkg::LIMIT_RESET;
            length_words = '0;
            run = ascpu_pkg::RUN_ACTIVE;
            mismatches = 0;
        endfunction

        function void write_register(logic idx, logic [CB-1:0] value);
            if (idx == ascpu_pkg::CFG_PROGRAM_LENGTH) begin
                length_words = value[LB-1:0];
            end else begin
                limit_steps = value;
            end
        endfunction

        // Executes one input item on the model and queues its result.
        function void note_input(logic [1:0] mode, logic [AB-1:0] addr, logic [31:0] data);
            t_machine_view r;
            logic [31:0]   word, imm, ea;
            r = '0;
            if (mode == ascpu_pkg::MODE_LOAD) begin
                code_mem[addr] = data;
                data_mem[addr] = data;
            end else if (mode == ascpu_pkg::MODE_STEP) begin
                if (run == ascpu_pkg::RUN_ACTIVE && pc >= length_words) begin
                    // Nothing left to execute: the program is finished.
                    run = ascpu_pkg::RUN_DONE;
                end else if (run == ascpu_pkg::RUN_ACTIVE) begin
                    word = code_mem[pc[AB-1:0]];
                    imm = {{8{word[31]}}, word[31:8]};
                    r.opcode = word[7:0];
                    pc = pc + 1;
                    if (executed != ascpu_pkg::COUNT_MAX) executed = executed + 1;
                    case (word[7:0])
                        ascpu_pkg::OP_LDC: begin
                            breg = acc;
                            acc = imm;
                        end
                        ascpu_pkg::OP_ADC: acc = acc + imm;
                        ascpu_pkg::OP_LDL: begin
                            ea = sp + imm;
                            breg = acc;
                            acc = data_mem[ea[AB-1:0]];
                            r.kind = ascpu_pkg::ACC_READ;
                            r.aaddr = ea[AB-1:0];
                        end
                        ascpu_pkg::OP_STL: begin
                            ea = sp + imm;
                            r.old = data_mem[ea[AB-1:0]];
                            data_mem[ea[AB-1:0]] = acc;
                            acc = breg;
                            r.kind = ascpu_pkg::ACC_WRITE;
                            r.aaddr = ea[AB-1:0];
                        end
                        ascpu_pkg::OP_LDNL: begin
                            // The address is formed from A before A is replaced.
                            ea = acc + imm;
                            acc = data_mem[ea[AB-1:0]];
                            r.kind = ascpu_pkg::ACC_READ;
                            r.aaddr = ea[AB-1:0];
                        end
                        ascpu_pkg::OP_STNL: begin
                            ea = acc + imm;
                            r.old = data_mem[ea[AB-1:0]];
                            data_mem[ea[AB-1:0]] = breg;
                            r.kind = ascpu_pkg::ACC_WRITE;
                            r.aaddr = ea[AB-1:0];
                        end
                        ascpu_pkg::OP_ADD: acc = acc + breg;
                        ascpu_pkg::OP_SUB: acc = breg - acc;
                        ascpu_pkg::OP_SHL: acc = (acc >= 32) ? 32'd0 : breg << acc[4:0];
                        ascpu_pkg::OP_SHR: acc = (acc >= 32) ? {32{breg[31]}}
                                                   : 32'($signed(breg) >>> acc[4:0]);
                        ascpu_pkg::OP_ADJ: sp = sp + imm;
                        ascpu_pkg::OP_A2SP: begin
                            sp = acc;
                            acc = breg;
                        end
                        ascpu_pkg::OP_SP2A: begin
                            breg = acc;
                            acc = sp;
                        end
                        ascpu_pkg::OP_CALL: begin
                            breg = acc;
                            acc = pc;
                            pc = pc + imm;
                        end
                        ascpu_pkg::OP_RETURN: begin
                            pc = acc;
                            acc = breg;
                        end
                        ascpu_pkg::OP_BRZ:  if (acc == 0) pc = pc + imm;
                        ascpu_pkg::OP_BRLZ: if (acc[31]) pc = pc + imm;
                        ascpu_pkg::OP_BR:   pc = pc + imm;
                        default: ;
                    endcase
                    if (pc[31] || pc > length_words || executed > limit_steps) begin
                        run = ascpu_pkg::RUN_ERROR;
                    end else if (word[7:0] >= ascpu_pkg::OP_HALT) begin
                        run = ascpu_pkg::RUN_HALTED;
                    end else if (pc >= length_words) begin
                        run = ascpu_pkg::RUN_DONE;
                    end
                end
            end else begin
                r.peek = data_mem[addr];
            end
            r.pc = pc;
            r.sp = sp;
            r.acc = acc;
            r.breg = breg;
            r.status = run;
            pending_results = {pending_results, r};
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            if (mismatches <= PRINT_LIMIT) begin
                $display("mismatch on %s: got %h, expected %h", what, got, want);
            end
        endtask

        // Compares one accepted result item with the oldest queued result.
        task check_result(logic [M_W-1:0] td, logic [1:0] tu);
            t_machine_view want;
            if (pending_results.size() == 0) begin
                report("result item with nothing pending", td[31:0], 32'd0);
                return;
            end
            want = pending_results.pop_front();
            if (td[31:0] !== want.pc) report("pc_out", td[31:0], want.pc);
            if (td[63:32] !== want.sp) report("sp_out", td[63:32], want.sp);
            if (td[95:64] !== want.acc) report("acc_out", td[95:64], want.acc);
            if (td[127:96] !== want.breg) report("regb_out", td[127:96], want.breg);
            if (td[F_STATUS+1:F_STATUS] !== want.status) begin
                report("status", 32'(td[F_STATUS+1:F_STATUS]), 32'(want.status));
            end
            if (td[F_OPCODE+7:F_OPCODE] !== want.opcode) begin
                report("executed_opcode", 32'(td[F_OPCODE+7:F_OPCODE]), 32'(want.opcode));
            end
            if (tu !== want.kind) report("access_kind", 32'(tu), 32'(want.kind));
            if (td[F_ADDR+AB-1:F_ADDR] !== want.aaddr) begin
                report("access_address", 32'(td[F_ADDR+AB-1:F_ADDR]), 32'(want.aaddr));
            end
            if (td[F_OLD+31:F_OLD] !== want.old) report("old_value", td[F_OLD+31:F_OLD], want.old);
            if (td[F_PEEK+31:F_PEEK] !== want.peek) begin
                report("peek_data", td[F_PEEK+31:F_PEEK], want.peek);
            end
        endtask
    endclass

    // Clock, reset and every input of the core start at known values.
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic [S_W-1:0]         i_s_axis_tdata = '0;
    logic [1:0]             i_s_axis_tuser = '0;
    logic                   i_m_axis_tready = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic                   i_cfg_index = 1'b0;
    logic [CB-1:0]          i_cfg_data = '0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [M_W-1:0]         o_m_axis_tdata;
    logic [1:0]             o_m_axis_tuser;

    core_mirror mirror;
    int         items_sent = 0;
    int         send_calm = 0;
    int         recv_calm = 0;
    int         cycle_count = 0;

    accumulator_stack_cpu_core #(
        .ADDR_BITS(AB)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        // tdata, lowest bit up: address[12], data[32], zero fill.
        .i_s_axis_tdata  (i_s_axis_tdata),
        // tuser: mode[2].
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        // tdata, lowest bit up: pc_out, sp_out, acc_out, regb_out, status,
        // executed_opcode, access_address, old_value, peek_data, zero fill.
        .o_m_axis_tdata  (o_m_axis_tdata),
        // tuser: access_kind[2].
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // A run that hangs on a handshake is stopped here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_accumulator_stack_cpu_core: errors");
            $finish;
        end
    end

    // Random idling before the next item, with occasional stretches in which
    // a side does not idle at all.
    function automatic int idle_cycles(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 40) == 0) calm = $urandom_range(10, 40);
        return $urandom_range(0, 4);
    endfunction

    // Offers one input item and waits for the core to accept it. A valid that
    // stays high for the next item is never dropped in between.
    task automatic send_item(logic [1:0] mode, logic [AB-1:0] addr, logic [31:0] data);
        int gap;
        gap = idle_cycles(send_calm);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= S_W'({data, addr});
        i_s_axis_tuser <= mode;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        mirror.note_input(mode, addr, data);
        items_sent++;
    endtask

    // Holds the sender back until every queued result has come out, then
    // lets the core settle.
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (mirror.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_setting(logic idx, logic [CB-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        mirror.write_register(idx, value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Builds an instruction for the current PC that keeps the machine running:
    // every jump lands inside the program and a fall-through never reaches its
    // end. Content is otherwise random.
    function automatic logic [31:0] next_instruction();
        logic [31:0] here, limit, target, arg;
        logic [7:0]  op;
        here = mirror.pc;
        limit = 32'(mirror.length_words);
        target = $urandom_range(0, limit - 1);
        arg = $urandom;
        op = 8'($urandom_range(ascpu_pkg::OP_LDC, ascpu_pkg::OP_BR));
        if (op == ascpu_pkg::OP_RETURN && mirror.acc >= limit) begin
            // A cannot serve as a return address yet; load one for later.
            op = ascpu_pkg::OP_LDC;
            arg = target;
        end else if (op == ascpu_pkg::OP_LDC && $urandom_range(0, 1) == 1) begin
            // Small constants make useful shift amounts.
            arg = $urandom_range(0, 40);
        end
        if (op inside {ascpu_pkg::OP_CALL, ascpu_pkg::OP_BR, ascpu_pkg::OP_BRZ,
                       ascpu_pkg::OP_BRLZ}) begin
            arg = target - here - 1;
        end
        if (here + 1 >= limit &&
            !(op inside {ascpu_pkg::OP_CALL, ascpu_pkg::OP_BR, ascpu_pkg::OP_RETURN})) begin
            op = ascpu_pkg::OP_BR;
            arg = target - here - 1;
        end
        return {arg[23:0], op};
    endfunction

    // Moves to a new program length and step limit while the core is idle.
    // The length always stays above the current PC.
    task automatic change_settings();
        logic [31:0] here;
        int unsigned len, lim;
        wait_idle();
        here = mirror.pc;
        case ($urandom_range(0, 2))
            0: len = MAX_LENGTH;
            1: len = $urandom_range(here + 1, MAX_LENGTH);
            default: len = $urandom_range(here + 1,
                                          (here + 40 > MAX_LENGTH) ? MAX_LENGTH : here + 40);
        endcase
        if ($urandom_range(0, 1) == 0) begin
            lim = MAX_LIMIT;
        end else begin
            lim = $urandom_range(mirror.executed + 2000, MAX_LIMIT);
        end
        write_setting(ascpu_pkg::CFG_PROGRAM_LENGTH, CB'(len));
        write_setting(ascpu_pkg::CFG_STEP_LIMIT, CB'(lim));
    endtask

    // End states are sticky until reset, so the run has exactly one of them;
    // the seed picks which one.
    task automatic end_program();
        logic [31:0] here, limit, arg;
        t_ending     how;
        here = mirror.pc;
        limit = 32'(mirror.length_words);
        how = t_ending'($urandom_range(END_HALT, END_LENGTH_CUT));
        case (how)
            END_HALT: begin
                send_item(ascpu_pkg::MODE_LOAD, here[AB-1:0],
                          {24'($urandom_range(0, 24'hFFFFFF)),
                           8'($urandom_range(ascpu_pkg::OP_HALT, 255))});
            end
            END_AT_LENGTH: begin
                arg = limit - here - 1;
                send_item(ascpu_pkg::MODE_LOAD, here[AB-1:0], {arg[23:0], ascpu_pkg::OP_BR});
            end
            END_PAST_LENGTH: begin
                arg = limit + $urandom_range(1, 1000) - here - 1;
                send_item(ascpu_pkg::MODE_LOAD, here[AB-1:0], {arg[23:0], ascpu_pkg::OP_BR});
            end
            END_NEGATIVE_PC: begin
                arg = 32'd0 - here - 1 - $urandom_range(1, 1000);
                send_item(ascpu_pkg::MODE_LOAD, here[AB-1:0], {arg[23:0], ascpu_pkg::OP_BR});
            end
            END_STEP_LIMIT: begin
                // The limit equals the steps taken, so the next one is too many.
                wait_idle();
                write_setting(ascpu_pkg::CFG_STEP_LIMIT, mirror.executed);
                send_item(ascpu_pkg::MODE_LOAD, here[AB-1:0], next_instruction());
            end
            default: begin
                // Cutting the length to the PC finishes without executing.
                wait_idle();
                write_setting(ascpu_pkg::CFG_PROGRAM_LENGTH, CB'(here));
            end
        endcase
        send_item(ascpu_pkg::MODE_STEP, AB'($urandom), $urandom);
    endtask

    // Result side: accepts result items with random stalls and checks them.
    initial begin
        int gap;
        forever begin
            gap = idle_cycles(recv_calm);
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
            mirror.check_result(o_m_axis_tdata, o_m_axis_tuser);
        end
    end

    // Stimulus. The core sweeps its data store after reset with tready low;
    // the first item simply waits for that to finish.
    initial begin
        logic [31:0] demo [0:9];
        int          pick, next_change;
        mirror = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Length at zero and the step limit at one; no step may run here, since a
        // step with a zero length would end the program.
        write_setting(ascpu_pkg::CFG_PROGRAM_LENGTH, '0);
        write_setting(ascpu_pkg::CFG_STEP_LIMIT, CB'(1));
        send_item(ascpu_pkg::MODE_LOAD, '1, 32'hFFFF_FFFF);
        send_item(ascpu_pkg::MODE_LOAD, '0, 32'h8000_0000);
        send_item(ascpu_pkg::MODE_LOAD, AB'(12'hAAA), 32'h5555_5555);
        send_item(ascpu_pkg::MODE_PEEK, '1, 32'h0);
        send_item(MODE_PEEK_ALT, AB'(12'h555), 32'hFFFF_FFFF);
        wait_idle();

        // Full length and the largest step limit for the rest of the run.
        write_setting(ascpu_pkg::CFG_PROGRAM_LENGTH, CB'(MAX_LENGTH));
        write_setting(ascpu_pkg::CFG_STEP_LIMIT, CB'(MAX_LIMIT));

        // A short program of corner cases: extreme operands, a shift right by
        // more than 31 with B negative, ldnl with a wrapping address taken
        // from A before the load, stnl below zero, a shift by zero, a call and
        // its return, and stl wrapping onto the top word written above.
        demo = '{{24'h800000, ascpu_pkg::OP_LDC}, {24'd40, ascpu_pkg::OP_LDC},
                 {24'd0, ascpu_pkg::OP_SHR}, {24'd5, ascpu_pkg::OP_LDNL},
                 {24'hFFFFFF, ascpu_pkg::OP_STNL}, {24'd0, ascpu_pkg::OP_LDC},
                 {24'd0, ascpu_pkg::OP_SHL}, {24'd1, ascpu_pkg::OP_CALL},
                 {24'h7FFFFF, ascpu_pkg::OP_STL}, {24'd0, ascpu_pkg::OP_RETURN}};
        foreach (demo[i]) send_item(ascpu_pkg::MODE_LOAD, AB'(i), demo[i]);
        repeat (10) send_item(ascpu_pkg::MODE_STEP, AB'($urandom), $urandom);

        // Random part: mostly a fresh instruction written at PC and then
        // executed, mixed with peeks of either peek code and stray loads that
        // fill the data store with random words.
        next_change = items_sent + $urandom_range(150, 300);
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= next_change) begin
                change_settings();
                next_change = items_sent + $urandom_range(150, 300);
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_item(ascpu_pkg::MODE_LOAD, mirror.pc[AB-1:0], next_instruction());
                send_item(ascpu_pkg::MODE_STEP, AB'($urandom), $urandom);
            end else if (pick < 88) begin
                send_item(($urandom_range(0, 1) == 0) ? ascpu_pkg::MODE_PEEK : MODE_PEEK_ALT,
                          AB'($urandom), $urandom);
            end else begin
                send_item(ascpu_pkg::MODE_LOAD, AB'($urandom), $urandom);
            end
        end

        end_program();

        // Once stopped, steps change nothing; loads and peeks still work.
        repeat (30) send_item(2'($urandom_range(0, 3)), AB'($urandom), $urandom);

        wait_idle();
        if (mirror.mismatches == 0) begin
            $display("tb_accumulator_stack_cpu_core: clean");
        end else begin
            $display("tb_accumulator_stack_cpu_core: errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/ascpu_pkg.sv
sv/ascpu_ram.sv
sv/ascpu_alu.sv
sv/accumulator_stack_cpu_core.sv
verif/tb_accumulator_stack_cpu_core.sv
